[sv/iafp_pkg.sv]
// Package for the IMU angle frame parser: frame constants and the bundle that
// carries a finished frame from the parser to the top level. No dependencies.
package iafp_pkg;

  // Frame framing bytes.
  localparam logic [7:0] HdrByte  = 8'h55;
  localparam logic [7:0] TypeByte = 8'h53;

  // Byte positions within the 11-byte frame.
  localparam logic [3:0] PosHunt      = 4'd0;
  localparam logic [3:0] PosType      = 4'd1;
  localparam logic [3:0] PosFirstData = 4'd2;
  localparam logic [3:0] PosLastKept  = 4'd7;
  localparam logic [3:0] PosLastData  = 4'd9;
  localparam logic [3:0] PosCheck     = 4'd10;

  // Number of kept payload bytes (frame bytes 2..7).
  localparam int unsigned PayloadDepth = 6;

  // Scale from raw word to degrees times 32768; yaw takes the negated scale.
  localparam logic signed [8:0] ScalePos = 9'sd180;
  localparam logic signed [8:0] ScaleNeg = -9'sd180;

  // Width of an output angle.
  localparam int unsigned AngleWidth = 24;

  // A checked frame, as raw little-endian words.
  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] roll_word;
    logic signed [15:0] pitch_word;
    logic signed [15:0] yaw_word;
  } frame_evt_t;

endpackage

[sv/iafp_parser.sv]
// Byte-level frame tracker: position counter, running checksum and payload
// store. Depends on iafp_pkg for framing constants and the frame_evt_t bundle.
module iafp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_accept,
  input  logic [7:0]         data_byte,
  output iafp_pkg::frame_evt_t frame_evt
);
  import iafp_pkg::*;

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  logic [7:0] sum_r;
  logic [7:0] sum_nxt;
  logic [7:0] payload_r [PayloadDepth];
  logic       store_en;
  logic [2:0] store_idx;
  logic       check_ok;

  // Next position and checksum for the byte in this transaction.
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    store_en  = 1'b0;
    check_ok  = 1'b0;
    store_idx = 3'(pos_r - PosFirstData);
    if (pos_r == PosType) begin
      if (data_byte == TypeByte) begin
        sum_nxt = sum_r + data_byte;
        pos_nxt = PosFirstData;
      end else if (data_byte == HdrByte) begin
        sum_nxt = data_byte;
        pos_nxt = PosType;
      end else begin
        pos_nxt = PosHunt;
      end
    end else if (pos_r inside {[PosFirstData:PosLastData]}) begin
      store_en = (pos_r <= PosLastKept);
      sum_nxt  = sum_r + data_byte;
      pos_nxt  = pos_r + 4'd1;
    end else if (pos_r == PosCheck) begin
      pos_nxt  = PosHunt;
      check_ok = (sum_r == data_byte);
    end else begin
      // Hunting for the header; unused positions behave the same way.
      if (data_byte == HdrByte) begin
        sum_nxt = data_byte;
        pos_nxt = PosType;
      end else begin
        pos_nxt = PosHunt;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= PosHunt;
      sum_r <= 8'd0;
    end else if (byte_accept) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Payload bytes; every entry is written within a frame before it is read.
  always_ff @(posedge clk) begin
    if (byte_accept && store_en) begin
      payload_r[store_idx] <= data_byte;
    end
  end

  // Frame event and the little-endian words it carries.
  assign frame_evt.frame_ok   = byte_accept & check_ok;
  assign frame_evt.roll_word  = {payload_r[1], payload_r[0]};
  assign frame_evt.pitch_word = {payload_r[3], payload_r[2]};
  assign frame_evt.yaw_word   = {payload_r[5], payload_r[4]};

endmodule

[sv/imu_angle_frame_parser_top.sv]
// IMU angle frame parser: takes one sensor byte per transaction and emits
// roll, pitch and negated yaw for each 11-byte angle frame with a good checksum.
// The result is registered in the output register, or in the skid register.
// Throughput: one byte per cycle; a two-entry output buffer (output register
// plus skid register) decouples the sides, so input stalls only when both hold.
// Reset (synchronous, rst_n low): hunting for the header, output buffer empty.
module imu_angle_frame_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [23:0]  out_roll_angle,
  output logic signed [23:0]  out_pitch_angle,
  output logic signed [23:0]  out_yaw_angle
);
  import iafp_pkg::*;

  typedef struct packed {
    logic signed [AngleWidth-1:0] roll;
    logic signed [AngleWidth-1:0] pitch;
    logic signed [AngleWidth-1:0] yaw;
  } angles_t;

  logic        in_accept;
  logic        out_fire;
  frame_evt_t  frame_evt;
  logic signed [24:0] roll_prod;
  logic signed [24:0] pitch_prod;
  logic signed [24:0] yaw_prod;
  angles_t     res;
  angles_t     out_r;
  angles_t     skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;

  assign in_accept = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;

  // Frame tracking and checksum.
  iafp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .data_byte   (in_data_byte),
    .frame_evt   (frame_evt)
  );

  // Scale raw words by 180; yaw uses the negated scale.
  assign roll_prod  = frame_evt.roll_word * ScalePos;
  assign pitch_prod = frame_evt.pitch_word * ScalePos;
  assign yaw_prod   = frame_evt.yaw_word * ScaleNeg;
  assign res.roll   = roll_prod[AngleWidth-1:0];
  assign res.pitch  = pitch_prod[AngleWidth-1:0];
  assign res.yaw    = yaw_prod[AngleWidth-1:0];

  // Output register and skid register valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= frame_evt.frame_ok;
      end
    end else if (frame_evt.frame_ok) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output and skid payloads.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (frame_evt.frame_ok) begin
      skid_r <= res;
    end
  end

  // Input stalls only while a result sits in the skid register.
  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_r.roll;
  assign out_pitch_angle = out_r.pitch;
  assign out_yaw_angle   = out_r.yaw;

endmodule
